// ===== hdl/mpfd_pkg.sv =====
// Shared types and constants of the Manchester pulse frame decoder.
// Holds the half class codes, status codes, register indexes and queue entry type.
// No dependencies.
package mpfd_pkg;

  localparam int unsigned NOMINAL_W   = 13;
  localparam int unsigned TOLERANCE_W = 12;
  localparam int unsigned DURATION_W  = 15;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned POSITION_W  = 6;

  localparam logic [NOMINAL_W-1:0]   RESET_HALF_BIT_NOMINAL = 13'd500;
  localparam logic [TOLERANCE_W-1:0] RESET_TOLERANCE_BELOW  = 12'd100;
  localparam logic [TOLERANCE_W-1:0] RESET_TOLERANCE_ABOVE  = 12'd150;

  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_BIT_NOMINAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE_BELOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE_ABOVE  = 2'd2;

  localparam logic [POSITION_W-1:0] START_POSITION = 6'd0;
  localparam logic [POSITION_W-1:0] STOP_POSITION  = 6'd33;

  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_TRANSITION  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_START_STOP = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LONG_TOO_EARLY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_DURATION   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INSUFFICIENT   = 3'd5;

  localparam logic [1:0] CLS_SHORT = 2'd0;
  localparam logic [1:0] CLS_LONG  = 2'd1;
  localparam logic [1:0] CLS_BAD   = 2'd2;

  typedef struct packed {
    logic       level;
    logic       dur_zero;
    logic [1:0] cls;
    logic       start;
    logic       last;
  } half_t;

endpackage

// ===== hdl/manchester_pulse_frame_decoder_core.sv =====
// Manchester pulse frame decoder, top level.
// Input channel: push with line_level, pulse_duration, frame_start and buffer_end;
//   an item is taken on a clock edge with push high and full low.
// Result channel: while empty is low the oldest result sits on frame_word,
//   status_code and error_bit_position; pop high with empty low takes it.
// Configuration: cfg_write, cfg_index, cfg_data write the half-bit nominal and
//   the two tolerances; write them only while no item is in flight.
// Throughput: one item per cycle while full is low. The front classifies
//   a half in the cycle it is taken and places it in a QUEUE_DEPTH-entry
//   queue; unless a result waits unpopped, the back retires one queued half
//   per cycle into a single result register. An item that causes a result
//   reaches the ports through a queue slot and then the result register.
// Stall: while a result waits unpopped, the back holds and the queue fills;
//   full rises once QUEUE_DEPTH items are queued.
// Reset (rst, synchronous): restores the default timing, empties queue and
//   result register, and leaves the decoder idle until a frame_start.
// Depends on mpfd_pkg, mpfd_front, mpfd_queue and mpfd_back.
module manchester_pulse_frame_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mpfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mpfd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic                               line_level,
  input  logic [mpfd_pkg::DURATION_W-1:0]    pulse_duration,
  input  logic                               frame_start,
  input  logic                               buffer_end,
  output logic                               empty,
  input  logic                               pop,
  output logic [mpfd_pkg::WORD_W-1:0]        frame_word,
  output logic [mpfd_pkg::STATUS_W-1:0]      status_code,
  output logic [mpfd_pkg::POSITION_W-1:0]    error_bit_position
);

  mpfd_pkg::half_t front_half;
  mpfd_pkg::half_t head;
  logic            avail;
  logic            take;

  mpfd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .line_level     (line_level),
    .pulse_duration (pulse_duration),
    .frame_start    (frame_start),
    .buffer_end     (buffer_end),
    .half           (front_half)
  );

  mpfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_half (front_half),
    .full      (full),
    .pop       (take),
    .head      (head),
    .avail     (avail)
  );

  mpfd_back u_back (
    .clk                (clk),
    .rst                (rst),
    .avail              (avail),
    .head               (head),
    .take               (take),
    .empty              (empty),
    .pop                (pop),
    .frame_word         (frame_word),
    .status_code        (status_code),
    .error_bit_position (error_bit_position)
  );

endmodule

// ===== hdl/mpfd_front.sv =====
// Front end of the Manchester pulse frame decoder: timing registers and half classifier.
// Classes each accepted half as short, long or bad against the current windows.
// Depends on mpfd_pkg.
module mpfd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mpfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mpfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                line_level,
  input  logic [mpfd_pkg::DURATION_W-1:0]     pulse_duration,
  input  logic                                frame_start,
  input  logic                                buffer_end,
  output mpfd_pkg::half_t                     half
);

  logic [mpfd_pkg::NOMINAL_W-1:0]   half_bit_nominal;
  logic [mpfd_pkg::TOLERANCE_W-1:0] tolerance_below;
  logic [mpfd_pkg::TOLERANCE_W-1:0] tolerance_above;

  logic [15:0] short_low_sum;
  logic [15:0] short_high_bound;
  logic [15:0] long_low_sum;
  logic [15:0] long_high_bound;
  logic [15:0] dur_ext;
  logic        fits_short;
  logic        is_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_nominal <= mpfd_pkg::RESET_HALF_BIT_NOMINAL;
      tolerance_below  <= mpfd_pkg::RESET_TOLERANCE_BELOW;
      tolerance_above  <= mpfd_pkg::RESET_TOLERANCE_ABOVE;
    end else if (cfg_write) begin
      case (cfg_index)
        mpfd_pkg::CFG_HALF_BIT_NOMINAL: half_bit_nominal <= cfg_data;
        mpfd_pkg::CFG_TOLERANCE_BELOW:  tolerance_below  <= cfg_data[mpfd_pkg::TOLERANCE_W-1:0];
        mpfd_pkg::CFG_TOLERANCE_ABOVE:  tolerance_above  <= cfg_data[mpfd_pkg::TOLERANCE_W-1:0];
        default: ;
      endcase
    end
  end

  // compare dur >= nom - tol as dur + tol >= nom to stay unsigned
  always_comb begin
    dur_ext          = {1'b0, pulse_duration};
    short_low_sum    = dur_ext + {4'd0, tolerance_below};
    short_high_bound = {3'd0, half_bit_nominal} + {4'd0, tolerance_above};
    long_low_sum     = dur_ext + {3'd0, tolerance_below, 1'b0};
    long_high_bound  = {2'd0, half_bit_nominal, 1'b0} + {3'd0, tolerance_above, 1'b0};
    fits_short = (short_low_sum >= {3'd0, half_bit_nominal}) && (dur_ext <= short_high_bound);
    is_long  = (long_low_sum >= {2'd0, half_bit_nominal, 1'b0}) && (dur_ext <= long_high_bound);
    half.level    = line_level;
    half.dur_zero = (pulse_duration == '0);
    half.start    = frame_start;
    half.last     = buffer_end;
    if (fits_short) begin
      half.cls = mpfd_pkg::CLS_SHORT;
    end else if (is_long) begin
      half.cls = mpfd_pkg::CLS_LONG;
    end else begin
      half.cls = mpfd_pkg::CLS_BAD;
    end
  end

endmodule

// ===== hdl/mpfd_queue.sv =====
// Short queue of classified halves between front and back of the frame decoder.
// Register array with wrapping pointers and a fill count.
// Depends on mpfd_pkg.
module mpfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mpfd_pkg::half_t push_half,
  output logic            full,
  input  logic            pop,
  output mpfd_pkg::half_t head,
  output logic            avail
);

  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

  mpfd_pkg::half_t slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == FULL_COUNT);
  assign avail   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_half;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/mpfd_back.sv =====
// Back end of the Manchester pulse frame decoder: bit recovery, frame state and result register.
// Turns classified halves into bits, tracks the frame and holds one result for the consumer.
// Depends on mpfd_pkg.
module mpfd_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               avail,
  input  mpfd_pkg::half_t                    head,
  output logic                               take,
  output logic                               empty,
  input  logic                               pop,
  output logic [mpfd_pkg::WORD_W-1:0]        frame_word,
  output logic [mpfd_pkg::STATUS_W-1:0]      status_code,
  output logic [mpfd_pkg::POSITION_W-1:0]    error_bit_position
);

  logic [mpfd_pkg::POSITION_W-1:0] bit_position;
  logic                            previous_level;
  logic                            half_phase;
  logic [mpfd_pkg::WORD_W-1:0]     shift_word;
  logic                            frame_active;
  logic                            out_valid;

  logic [mpfd_pkg::POSITION_W-1:0] pos_e;
  logic                            prev_e;
  logic                            phase_e;
  logic [mpfd_pkg::WORD_W-1:0]     word_e;
  logic                            active_e;

  logic [mpfd_pkg::POSITION_W-1:0] bit_position_next;
  logic                            previous_level_next;
  logic                            half_phase_next;
  logic [mpfd_pkg::WORD_W-1:0]     shift_word_next;
  logic                            frame_active_next;

  logic                            fire;
  logic [mpfd_pkg::STATUS_W-1:0]   res_code;
  logic [mpfd_pkg::POSITION_W-1:0] res_pos;
  logic                            bit_ok;
  logic                            bit_val;

  assign empty = !out_valid;
  assign take  = avail && (!out_valid || pop);

  always_comb begin
    pos_e    = head.start ? '0 : bit_position;
    prev_e   = head.start ? 1'b0 : previous_level;
    phase_e  = head.start ? 1'b0 : half_phase;
    word_e   = head.start ? '0 : shift_word;
    active_e = head.start | frame_active;

    bit_position_next   = pos_e;
    previous_level_next = prev_e;
    half_phase_next     = phase_e;
    shift_word_next     = word_e;
    frame_active_next   = active_e;

    fire     = 1'b0;
    res_code = mpfd_pkg::ST_OK;
    res_pos  = '0;
    bit_ok   = 1'b0;
    bit_val  = 1'b0;

    if (active_e) begin
      if (head.dur_zero && (pos_e == mpfd_pkg::STOP_POSITION)) begin
        fire = 1'b1;
        if (!head.level && prev_e) begin
          res_code = mpfd_pkg::ST_OK;
          res_pos  = '0;
        end else begin
          res_code = mpfd_pkg::ST_BAD_START_STOP;
          res_pos  = pos_e;
        end
      end else begin
        previous_level_next = head.level;
        case (head.cls)
          mpfd_pkg::CLS_SHORT: begin
            half_phase_next = ~phase_e;
            if (phase_e) begin
              if (prev_e == head.level) begin
                fire     = 1'b1;
                res_code = mpfd_pkg::ST_NO_TRANSITION;
                res_pos  = pos_e;
              end else begin
                bit_ok  = 1'b1;
                bit_val = ~head.level;
              end
            end
          end
          mpfd_pkg::CLS_LONG: begin
            if (phase_e) begin
              if (prev_e == head.level) begin
                fire     = 1'b1;
                res_code = mpfd_pkg::ST_NO_TRANSITION;
                res_pos  = pos_e;
              end else begin
                bit_ok  = 1'b1;
                bit_val = ~head.level;
              end
            end else begin
              fire     = 1'b1;
              res_code = mpfd_pkg::ST_LONG_TOO_EARLY;
              res_pos  = pos_e;
            end
          end
          default: begin
            fire     = 1'b1;
            res_code = mpfd_pkg::ST_BAD_DURATION;
            res_pos  = pos_e;
          end
        endcase

        if (bit_ok) begin
          if ((pos_e == mpfd_pkg::START_POSITION) || (pos_e == mpfd_pkg::STOP_POSITION)) begin
            if (!bit_val) begin
              fire     = 1'b1;
              res_code = mpfd_pkg::ST_BAD_START_STOP;
              res_pos  = pos_e;
            end else if (pos_e == mpfd_pkg::STOP_POSITION) begin
              fire     = 1'b1;
              res_code = mpfd_pkg::ST_OK;
              res_pos  = '0;
            end else begin
              bit_position_next = pos_e + 1'b1;
            end
          end else begin
            shift_word_next   = {word_e[mpfd_pkg::WORD_W-2:0], bit_val};
            bit_position_next = pos_e + 1'b1;
          end
        end
      end

      if (!fire && head.last) begin
        fire     = 1'b1;
        res_code = mpfd_pkg::ST_INSUFFICIENT;
        res_pos  = bit_position_next;
      end
      if (fire) begin
        frame_active_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position   <= '0;
      previous_level <= 1'b0;
      half_phase     <= 1'b0;
      shift_word     <= '0;
      frame_active   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        bit_position   <= bit_position_next;
        previous_level <= previous_level_next;
        half_phase     <= half_phase_next;
        shift_word     <= shift_word_next;
        frame_active   <= frame_active_next;
      end
      if (take && fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && fire) begin
      frame_word         <= shift_word_next;
      status_code        <= res_code;
      error_bit_position <= res_pos;
    end
  end

endmodule
